// ===== design/alst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_pkg
// Shared types and constants of the array list block: operation codes,
// field widths and the result record passed from the sequencer to the top.
// ----------------------------------------------------------------------------
package alst_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int OP_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef struct packed {
		logic              status;
		logic              has_element;
		logic [DATA_W-1:0] element;
		logic              last;
	} res_t;

endpackage

// ===== design/array_list_insert_remove_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_remove_search
// Ordered list of signed 32-bit values with insert, remove, search and dump.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries op, position and value; one
// item is taken at a time and in_stall stays high until its last result has
// moved into the output register.
// Output channel (out_valid / out_stall) carries status, has_element,
// element and last; last marks the final result of an item.
// Search always scans the whole list. Dump streams entries from the registered
// read data, one entry per cycle while the receiver does not stall.
// Failures and an empty dump give a single result. The input opens again once
// the sequencer is back to idle after the last result has been loaded.
// The entry store has a single read port, walked one address per cycle
// unless a dump is held by the receiver.
// Reset clears the entry count and the sequencer; the store keeps no reset.
// While out_stall is high and a result is held, the output register holds,
// and a dump pauses its store reads with the next entry held in the read data register.
// ----------------------------------------------------------------------------
module array_list_insert_remove_search #(
	parameter int CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [alst_pkg::OP_W-1:0]          op,
	input  logic [alst_pkg::POS_W-1:0]         position,
	input  logic signed [alst_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               status,
	output logic                               has_element,
	output logic signed [alst_pkg::DATA_W-1:0] element,
	output logic                               last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic                        res_valid;
	logic                        res_ready;
	alst_pkg::res_t              res;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [alst_pkg::DATA_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [alst_pkg::DATA_W-1:0] mem_rdata;

	logic           out_valid_q;
	alst_pkg::res_t out_q;

	alst_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.position  (position),
		.value     ($unsigned(value)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	alst_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Load when empty or when the held result transfers this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign has_element = out_q.has_element;
	assign element     = $signed(out_q.element);
	assign last        = out_q.last;

endmodule

// ===== design/alst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_ram
// Entry store: one write port, one read port with read enable. Read data is
// registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module alst_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [alst_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [alst_pkg::DATA_W-1:0] rdata
);

	logic [alst_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/alst_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_seq
// Operation sequencer: decodes an accepted item and walks the entry store
// one address per cycle, shifting entries for insert and remove, comparing
// for search and streaming entries for dump as the output takes them.
// ----------------------------------------------------------------------------
module alst_seq #(
	parameter int CAPACITY = 32,
	parameter int AW       = 5,
	parameter int CW       = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [alst_pkg::OP_W-1:0]   op,
	input  logic [alst_pkg::POS_W-1:0]  position,
	input  logic [alst_pkg::DATA_W-1:0] value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output alst_pkg::res_t              res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [alst_pkg::DATA_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [alst_pkg::DATA_W-1:0] mem_rdata
);

	localparam int MW = (CW > alst_pkg::POS_W) ? CW : alst_pkg::POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHIFT = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DUMP  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                      state_q;
	alst_pkg::op_t               op_q;
	logic [AW-1:0]               pos_q;
	logic [alst_pkg::DATA_W-1:0] value_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rem_q;
	logic [AW-1:0]               rd_idx_q;
	logic                        found_q;
	logic                        resp_status_q;
	logic                        v_s1;
	logic                        last_s1;
	logic [AW-1:0]               waddr_s1;

	logic          acc;
	logic          ins_ok;
	logic          rem_ok;
	logic          issue;
	logic          res_take;
	logic          walk_done;
	logic [MW-1:0] pos_ext;
	logic [MW-1:0] cnt_ext;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && (state_q == S_IDLE);
	assign pos_ext  = MW'(position);
	assign cnt_ext  = MW'(count_q);
	assign ins_ok   = (pos_ext <= cnt_ext) && (count_q != CAP_C);
	assign rem_ok   = (pos_ext < cnt_ext);

	assign res_valid = (state_q == S_RESP) || ((state_q == S_DUMP) && v_s1);
	assign res_take  = res_valid && res_ready;
	assign walk_done = (rem_q == '0) && !v_s1;

	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			S_SHIFT, S_SCAN: issue = (rem_q != '0);
			S_DUMP:          issue = (rem_q != '0) && (!v_s1 || res_take);
			default:         issue = 1'b0;
		endcase
	end

	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q;

	// Shift writes come straight from the read data; the inserted value goes
	// in once the shift has drained.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_s1;
		mem_wdata = mem_rdata;
		if (state_q == S_SHIFT) begin
			if (v_s1) begin
				mem_we = 1'b1;
			end else if (rem_q == '0 && op_q == alst_pkg::OP_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = value_q;
			end
		end
	end

	always_comb begin
		res.status      = (state_q == S_RESP) ? resp_status_q : 1'b0;
		res.has_element = (state_q == S_DUMP);
		res.element     = (state_q == S_DUMP) ? mem_rdata : '0;
		res.last        = (state_q == S_RESP) ? 1'b1 : last_s1;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q   <= position[AW-1:0];
			value_q <= value;
		end
		if (state_q == S_SHIFT || state_q == S_SCAN) begin
			waddr_s1 <= (op_q == alst_pkg::OP_INSERT) ? rd_idx_q + AW'(1)
			                                          : rd_idx_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= alst_pkg::OP_INSERT;
			count_q       <= '0;
			rem_q         <= '0;
			rd_idx_q      <= '0;
			found_q       <= 1'b0;
			resp_status_q <= 1'b0;
			v_s1          <= 1'b0;
			last_s1       <= 1'b0;
		end else begin
			if (issue) begin
				rem_q    <= rem_q - CW'(1);
				rd_idx_q <= (op_q == alst_pkg::OP_INSERT) ? rd_idx_q - AW'(1)
				                                          : rd_idx_q + AW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (acc) begin
						op_q <= alst_pkg::op_t'(op);
						unique case (alst_pkg::op_t'(op))
							alst_pkg::OP_INSERT: begin
								if (ins_ok) begin
									state_q  <= S_SHIFT;
									rem_q    <= count_q - CW'(position);
									rd_idx_q <= AW'(count_q - CW'(1));
								end else begin
									resp_status_q <= 1'b1;
									state_q       <= S_RESP;
								end
							end
							alst_pkg::OP_REMOVE: begin
								if (rem_ok) begin
									state_q  <= S_SHIFT;
									rem_q    <= count_q - CW'(1) - CW'(position);
									rd_idx_q <= position[AW-1:0] + AW'(1);
								end else begin
									resp_status_q <= 1'b1;
									state_q       <= S_RESP;
								end
							end
							alst_pkg::OP_SEARCH: begin
								state_q  <= S_SCAN;
								rem_q    <= count_q;
								rd_idx_q <= '0;
								found_q  <= 1'b0;
							end
							default: begin
								if (count_q == '0) begin
									resp_status_q <= 1'b0;
									state_q       <= S_RESP;
								end else begin
									state_q  <= S_DUMP;
									rem_q    <= count_q;
									rd_idx_q <= '0;
								end
							end
						endcase
					end
				end
				S_SHIFT: begin
					v_s1 <= issue;
					if (walk_done) begin
						count_q       <= (op_q == alst_pkg::OP_INSERT) ? count_q + CW'(1)
						                                               : count_q - CW'(1);
						resp_status_q <= 1'b0;
						state_q       <= S_RESP;
					end
				end
				S_SCAN: begin
					v_s1 <= issue;
					if (v_s1 && mem_rdata == value_q) begin
						found_q <= 1'b1;
					end
					if (walk_done) begin
						resp_status_q <= !found_q;
						state_q       <= S_RESP;
					end
				end
				S_DUMP: begin
					// Hold the read data until the output side takes it.
					if (issue) begin
						v_s1    <= 1'b1;
						last_s1 <= (rem_q == CW'(1));
					end else if (res_take) begin
						v_s1 <= 1'b0;
					end
					if (walk_done) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					v_s1 <= 1'b0;
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					v_s1    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write to the same entry in one cycle");

	a_dump_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP || state_q == S_SCAN) |-> !mem_we)
		else $error("store written during a read-only walk");

	a_dump_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && v_s1 && !res_take) |=> (v_s1 && $stable(mem_rdata)))
		else $error("pending dump entry lost before transfer");

endmodule
